// ===== design/mmrh_pkg.sv =====
// Package for the min/max range histogram unit: sizes, field widths, controller states
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mmrh_pkg;

    localparam int MaxSamples = 1024;
    localparam int MaxBins    = 64;
    localparam int AddrW      = $clog2(MaxSamples);
    localparam int CountW     = $clog2(MaxSamples + 1);
    localparam int BinW       = $clog2(MaxBins);
    localparam int TotalW     = 11;
    localparam logic [TotalW-1:0] CountLimit = 11'd2047;
    // Quotient bits of a bin select, and the divider numerator width.
    localparam int QuotW      = 7;
    localparam int NumW       = 32 + QuotW + 1;

    localparam logic [0:0] RegBinCount = 1'b0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_READ,
        ST_DIVIDE,
        ST_COUNT,
        ST_BUMP,
        ST_EDGE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic store_sample;
        logic start_pass;
        logic clear_bin;
        logic read_sample;
        logic start_bin_div;
        logic div_step;
        logic fetch_bin;
        logic count_bin;
        logic start_edge_div;
        logic emit_load;
        logic next_sample;
        logic next_bin;
        logic end_pass;
    } ctrl_t;

    typedef struct packed {
        logic samples_done;
        logic bins_done;
        logic div_done;
        logic empty_set;
    } status_t;

endpackage

// ===== design/mmrh_ctrl.sv =====
// Controller state machine for the min/max range histogram unit.
// Depends on mmrh_pkg for the state type and command/status structs.
`timescale 1ns / 1ps

module mmrh_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_last,
    input  logic              out_free,
    input  mmrh_pkg::status_t status,
    output mmrh_pkg::ctrl_t   ctrl,
    output logic              busy
);

    mmrh_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmrh_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        unique case (state_reg)
            mmrh_pkg::ST_LOAD:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    ctrl.store_sample = 1'b1;
                    if (in_last)
                    begin
                        ctrl.start_pass = 1'b1;
                        state_next = mmrh_pkg::ST_CLEAR;
                    end
                end
            end
            mmrh_pkg::ST_CLEAR:
            begin
                ctrl.clear_bin = 1'b1;
                ctrl.next_bin  = 1'b1;
                if (status.bins_done)
                begin
                    state_next = status.empty_set ? mmrh_pkg::ST_EMIT : mmrh_pkg::ST_READ;
                end
            end
            mmrh_pkg::ST_READ:
            begin
                ctrl.read_sample = 1'b1;
                state_next = mmrh_pkg::ST_DIVIDE;
            end
            mmrh_pkg::ST_DIVIDE:
            begin
                ctrl.start_bin_div = 1'b1;
                state_next = mmrh_pkg::ST_COUNT;
            end
            mmrh_pkg::ST_COUNT:
            begin
                if (status.div_done)
                begin
                    ctrl.fetch_bin = 1'b1;
                    state_next = mmrh_pkg::ST_BUMP;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            mmrh_pkg::ST_BUMP:
            begin
                ctrl.count_bin   = 1'b1;
                ctrl.next_sample = 1'b1;
                state_next = status.samples_done ? mmrh_pkg::ST_EMIT : mmrh_pkg::ST_READ;
            end
            mmrh_pkg::ST_EDGE:
            begin
                if (status.div_done)
                begin
                    if (out_free)
                    begin
                        ctrl.emit_load = 1'b1;
                        ctrl.next_bin  = 1'b1;
                        if (status.bins_done)
                        begin
                            ctrl.end_pass = 1'b1;
                            state_next = mmrh_pkg::ST_LOAD;
                        end
                        else
                        begin
                            state_next = mmrh_pkg::ST_EMIT;
                        end
                    end
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            mmrh_pkg::ST_EMIT:
            begin
                ctrl.start_edge_div = 1'b1;
                state_next = mmrh_pkg::ST_EDGE;
            end
            default:
            begin
                state_next = mmrh_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== design/mmrh_datapath.sv =====
// Datapath of the min/max range histogram unit: sample memory, min/max tracking,
// bin count array, shared restoring divider and output register. Depends on mmrh_pkg.
`timescale 1ns / 1ps

module mmrh_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mmrh_pkg::ctrl_t               ctrl,
    output mmrh_pkg::status_t             status,
    input  logic signed [31:0]            sample_value,
    input  logic [6:0]                    bin_count,
    output logic                          out_valid,
    input  logic                          out_taken,
    output logic [mmrh_pkg::BinW-1:0]     bin_index,
    output logic [mmrh_pkg::TotalW-1:0]   bin_total,
    output logic signed [31:0]            bin_edge,
    output logic                          last_bin
);

    localparam int AW = mmrh_pkg::AddrW;
    localparam int CW = mmrh_pkg::CountW;
    localparam int BW = mmrh_pkg::BinW;
    localparam int TW = mmrh_pkg::TotalW;
    localparam int QW = mmrh_pkg::QuotW;
    localparam int NW = mmrh_pkg::NumW;

    logic signed [31:0] mem [mmrh_pkg::MaxSamples];
    logic signed [31:0] rd_data_reg;

    logic [CW-1:0]      stored_reg;
    logic signed [31:0] min_reg, max_reg;
    logic [CW-1:0]      rd_ptr_reg;
    logic [BW:0]        bin_ptr_reg;
    logic [6:0]         bins_reg;
    logic [6:0]         bins_m1;
    logic [TW-1:0]      counts_reg [mmrh_pkg::MaxBins];
    logic [TW-1:0]      cnt_rd_reg;
    logic [BW-1:0]      tgt_reg;
    logic [32:0]        span;
    logic [32:0]        offset;

    // Restoring divider. A bin select divides offset*(B-1) by the span and needs
    // only QW quotient bits; an edge label divides span*i by B-1 over all NW bits.
    logic [NW-1:0]      num_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        dvsr_reg;
    logic [NW-1:0]      quot_reg;
    logic [5:0]         step_reg;
    logic               div_run_reg;
    logic [33:0]        trial;
    logic [NW-1:0]      num_load;
    logic               div_load;
    logic               is_max_reg;

    logic [BW-1:0]      tgt_bin;
    logic [6:0]         eff_bins;

    assign span    = {max_reg[31], max_reg} - {min_reg[31], min_reg};
    assign offset  = {rd_data_reg[31], rd_data_reg} - {min_reg[31], min_reg};
    assign bins_m1 = bins_reg - 7'd1;

    always_comb
    begin
        eff_bins = bin_count;
        if (bin_count < 7'd2)
        begin
            eff_bins = 7'd2;
        end
        else if (bin_count > 7'(mmrh_pkg::MaxBins))
        begin
            eff_bins = 7'(mmrh_pkg::MaxBins);
        end
    end

    // Numerator for a bin select (offset*(B-1)) or an edge label (span*i).
    always_comb
    begin
        div_load = ctrl.start_bin_div || ctrl.start_edge_div;
        if (ctrl.start_bin_div)
        begin
            num_load = NW'(offset) * NW'(bins_m1);
        end
        else
        begin
            num_load = NW'(span) * NW'(bin_ptr_reg);
        end
    end

    assign trial = {rem_reg, num_reg[NW-1]} - {1'b0, dvsr_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.store_sample && stored_reg < CW'(mmrh_pkg::MaxSamples))
        begin
            mem[stored_reg[AW-1:0]] <= sample_value;
        end
        if (ctrl.read_sample)
        begin
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg  <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            rd_ptr_reg  <= '0;
            bin_ptr_reg <= '0;
            bins_reg    <= 7'(mmrh_pkg::MaxBins);
            div_run_reg <= 1'b0;
            step_reg    <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (out_taken)
            begin
                out_valid <= 1'b0;
            end
            if (ctrl.store_sample && stored_reg < CW'(mmrh_pkg::MaxSamples))
            begin
                stored_reg <= stored_reg + CW'(1);
                if (stored_reg == '0 || sample_value < min_reg)
                begin
                    min_reg <= sample_value;
                end
                if (stored_reg == '0 || sample_value > max_reg)
                begin
                    max_reg <= sample_value;
                end
            end
            if (ctrl.start_pass)
            begin
                bins_reg    <= eff_bins;
                bin_ptr_reg <= '0;
                rd_ptr_reg  <= '0;
            end
            if (ctrl.next_bin)
            begin
                bin_ptr_reg <= status.bins_done ? '0 : bin_ptr_reg + 1'b1;
            end
            if (ctrl.next_sample)
            begin
                rd_ptr_reg <= rd_ptr_reg + CW'(1);
            end
            // The step counter runs down to zero; a bin select is QW steps long.
            if (div_load)
            begin
                div_run_reg <= 1'b1;
                step_reg    <= ctrl.start_bin_div ? 6'(QW - 1) : 6'(NW - 1);
            end
            else if (ctrl.div_step)
            begin
                step_reg <= step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    div_run_reg <= 1'b0;
                end
            end
            if (ctrl.emit_load)
            begin
                out_valid <= 1'b1;
            end
            if (ctrl.end_pass)
            begin
                stored_reg <= '0;
                min_reg    <= '0;
                max_reg    <= '0;
            end
        end
    end

    // For a bin select offset <= span, so offset*(B-1) >> QW is already below the
    // span and only the low QW numerator bits remain to be shifted in.
    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            quot_reg <= '0;
            if (ctrl.start_bin_div)
            begin
                num_reg    <= num_load << (NW - QW);
                rem_reg    <= num_load[NW-1:QW];
                dvsr_reg   <= span;
                is_max_reg <= (rd_data_reg == max_reg) || (span == '0);
            end
            else
            begin
                num_reg  <= num_load;
                rem_reg  <= '0;
                dvsr_reg <= {26'd0, bins_m1};
            end
        end
        else if (ctrl.div_step)
        begin
            num_reg <= num_reg << 1;
            if (!trial[33])
            begin
                rem_reg  <= trial[32:0];
                quot_reg <= {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[31:0], num_reg[NW-1]};
                quot_reg <= {quot_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (is_max_reg || quot_reg > NW'(bins_reg - 7'd2))
        begin
            tgt_bin = BW'(bins_reg - 7'd2);
        end
        else
        begin
            tgt_bin = quot_reg[BW-1:0];
        end
    end

    // Counts are read into a register and written back in the next cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear_bin)
        begin
            counts_reg[bin_ptr_reg[BW-1:0]] <= '0;
        end
        else if (ctrl.count_bin && cnt_rd_reg != mmrh_pkg::CountLimit)
        begin
            counts_reg[tgt_reg] <= cnt_rd_reg + TW'(1);
        end
        if (ctrl.fetch_bin)
        begin
            cnt_rd_reg <= counts_reg[tgt_bin];
            tgt_reg    <= tgt_bin;
        end
        if (ctrl.emit_load)
        begin
            bin_index <= bin_ptr_reg[BW-1:0];
            bin_total <= counts_reg[bin_ptr_reg[BW-1:0]];
            bin_edge  <= min_reg + quot_reg[31:0];
            last_bin  <= (bin_ptr_reg == bins_m1);
        end
    end

    assign status.samples_done = (rd_ptr_reg + CW'(1) >= stored_reg);
    assign status.bins_done    = (bin_ptr_reg + 7'd1 >= bins_reg);
    assign status.div_done     = !div_run_reg;
    assign status.empty_set    = (stored_reg == '0);

    property p_no_clear_count;
        @(posedge clk) disable iff (!rst_n) !(ctrl.count_bin && ctrl.clear_bin);
    endproperty
    a_no_clear_count: assert property (p_no_clear_count)
        else $error("count and clear in the same cycle");

    property p_div_len;
        @(posedge clk) disable iff (!rst_n) div_load |=> !status.div_done;
    endproperty
    a_div_len: assert property (p_div_len) else $error("divider did not start");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n) (out_valid && !out_taken) |=> out_valid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_out_stable;
        @(posedge clk) disable iff (!rst_n) (out_valid && !out_taken)
            |=> $stable({bin_index, bin_total, bin_edge, last_bin});
    endproperty
    a_out_stable: assert property (p_out_stable) else $error("waiting result changed");

    property p_store_bound;
        @(posedge clk) disable iff (!rst_n) stored_reg <= CW'(mmrh_pkg::MaxSamples);
    endproperty
    a_store_bound: assert property (p_store_bound) else $error("store count overflow");

endmodule

// ===== design/min_max_range_histogram_unit.sv =====
// Top level of the min/max range histogram unit: stream ports, APB register,
// controller and datapath. Depends on mmrh_pkg, mmrh_ctrl and mmrh_datapath.
`timescale 1ns / 1ps
//
// channel  | direction | payload
// s_axis   | in        | tdata[31:0] sample_value, tlast final_sample
// m_axis   | out       | tdata[48:0] bin_index, bin_total, bin_edge; tlast last_bin
// apb      | in/out    | register 0 at address 0: bin_count[6:0]
//
// A sample transaction is taken every cycle while loading. The final
// transaction starts a pass: the counts are cleared bin by bin, then each
// sample takes a memory read, divider start, 7 divider steps, count fetch
// and count update, then each bin a divider start, 40 steps for the edge
// label and one output load, plus any wait of the output register.
// Reset clears all control state; the sample memory needs no clearing.
// s_axis_tready is low during the pass; a stalled result holds the pass.

module min_max_range_histogram_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
    input  logic        s_axis_tlast,   // final_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [5:0] bin_index, [16:6] bin_total, [48:17] bin_edge
    output logic        m_axis_tlast,   // last_bin
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mmrh_pkg::ctrl_t   ctrl;
    mmrh_pkg::status_t status;
    logic              busy;
    logic [6:0]        bin_count_reg;
    logic [5:0]        bin_index;
    logic [10:0]       bin_total;
    logic signed [31:0] bin_edge;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= 7'd64;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            bin_count_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr == 2'b00) ? {25'd0, bin_count_reg} : 32'd0;

    assign s_axis_tready = !busy;

    mmrh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .in_last  (s_axis_tlast),
        .out_free (!m_axis_tvalid || m_axis_tready),
        .status   (status),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    mmrh_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .sample_value (s_axis_tdata),
        .bin_count    (bin_count_reg),
        .out_valid    (m_axis_tvalid),
        .out_taken    (m_axis_tready),
        .bin_index    (bin_index),
        .bin_total    (bin_total),
        .bin_edge     (bin_edge),
        .last_bin     (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, bin_edge, bin_total, bin_index};

endmodule
